// ===== src/i2cee_pkg.sv =====
package i2cee_pkg;

	// opcodes of an input beat
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_SUPPLY = 2'd3;

	// completion status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DEV_NACK = 2'd1;
	localparam logic [1:0] STAT_WA_NACK  = 2'd2;
	localparam logic [1:0] STAT_DAT_NACK = 2'd3;

	localparam logic [8:0] MAX_BYTE_COUNT = 9'd256;
	localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

	// register map
	localparam logic [2:0] ADDR_DEV = 3'd0;

	// classified command handed from front to engine
	typedef struct packed {
		logic       begin_op;
		logic       read_op;
		logic       supply_op;
		logic [7:0] word_addr;
		logic [8:0] count;
		logic [7:0] tx_byte;
		logic       sda;
	} cmd_t;

	typedef struct packed {
		logic       scl;
		logic       sda_release;
		logic       busy_res;
		logic       need_data;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       done_res;
		logic [1:0] status;
	} res_t;

endpackage

// ===== src/i2cee_front.sv =====
module i2cee_front import i2cee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] word_addr,
	input  logic [8:0] byte_count,
	input  logic [7:0] tx_byte,
	input  logic       sda_in,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       q_ready
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic [8:0] cnt_sat;

	always_comb begin
		cnt_sat = (byte_count > MAX_BYTE_COUNT) ? MAX_BYTE_COUNT : byte_count;
		cmd_d.begin_op  = (opcode == OP_WRITE) || (opcode == OP_READ);
		cmd_d.read_op   = (opcode == OP_READ);
		cmd_d.supply_op = (opcode == OP_SUPPLY);
		cmd_d.word_addr = word_addr;
		// a read of zero bytes still reads one
		cmd_d.count     = ((opcode == OP_READ) && (cnt_sat == 9'd0)) ? 9'd1 : cnt_sat;
		cmd_d.tx_byte   = tx_byte;
		cmd_d.sda       = sda_in;
	end

	assign in_stall = valid_s1 && !q_ready;
	assign push     = valid_s1 && q_ready;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// ===== src/i2cee_queue.sv =====
module i2cee_queue import i2cee_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic q_ready,
	output logic q_valid,
	output cmd_t q_cmd,
	input  logic pop
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/i2cee_engine.sv =====
module i2cee_engine import i2cee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] dev_addr,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output res_t       res
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_START    = 4'd1;
	localparam logic [3:0] S_DEVW     = 4'd2;
	localparam logic [3:0] S_DEVW_ACK = 4'd3;
	localparam logic [3:0] S_WORD     = 4'd4;
	localparam logic [3:0] S_WORD_ACK = 4'd5;
	localparam logic [3:0] S_WAIT     = 4'd6;
	localparam logic [3:0] S_DATA     = 4'd7;
	localparam logic [3:0] S_DATA_ACK = 4'd8;
	localparam logic [3:0] S_RSTART   = 4'd9;
	localparam logic [3:0] S_DEVR     = 4'd10;
	localparam logic [3:0] S_DEVR_ACK = 4'd11;
	localparam logic [3:0] S_RECV     = 4'd12;
	localparam logic [3:0] S_MACK     = 4'd13;
	localparam logic [3:0] S_STOP     = 4'd14;

	logic [3:0] st_q, st_d;
	logic [1:0] ph_q, ph_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] sh_q, sh_d;
	logic [8:0] left_q, left_d;
	logic [7:0] addr_q, addr_d;
	logic       rd_q, rd_d;
	logic [1:0] lst_q, lst_d;
	logic [8:0] left_dec;
	res_t       r;
	logic       out_valid_q;
	res_t       res_q;

	assign pop       = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign left_dec  = (left_q != 9'd0) ? (left_q - 9'd1) : 9'd0;

	always_comb begin
		st_d   = st_q;
		ph_d   = ph_q;
		bit_d  = bit_q;
		sh_d   = sh_q;
		left_d = left_q;
		addr_d = addr_q;
		rd_d   = rd_q;
		lst_d  = lst_q;
		r             = '0;
		r.scl         = 1'b1;
		r.sda_release = 1'b1;

		unique case (st_q)
			S_IDLE: begin
				if (q_cmd.begin_op) begin
					rd_d   = q_cmd.read_op;
					addr_d = q_cmd.word_addr;
					left_d = q_cmd.count;
					lst_d  = STAT_OK;
					ph_d   = 2'd0;
					bit_d  = 3'd0;
					st_d   = S_START;
				end
			end
			S_START, S_RSTART: begin
				if (ph_q == 2'd0) begin
					ph_d = 2'd1;
				end else if (ph_q == 2'd1) begin
					r.sda_release = 1'b0;
					ph_d = 2'd2;
				end else begin
					r.scl         = 1'b0;
					r.sda_release = 1'b0;
					sh_d  = {dev_addr, (st_q == S_RSTART)};
					st_d  = (st_q == S_START) ? S_DEVW : S_DEVR;
					ph_d  = 2'd0;
					bit_d = 3'd0;
				end
			end
			S_DEVW, S_WORD, S_DATA, S_DEVR: begin
				r.sda_release = sh_q[3'd7 - bit_q];
				r.scl         = (ph_q == 2'd1);
				if (ph_q != 2'd2) begin
					ph_d = ph_q + 2'd1;
				end else begin
					ph_d = 2'd0;
					if (bit_q != 3'd7) begin
						bit_d = bit_q + 3'd1;
					end else begin
						bit_d = 3'd0;
						st_d  = st_q + 4'd1;
					end
				end
			end
			S_DEVW_ACK, S_WORD_ACK, S_DATA_ACK, S_DEVR_ACK: begin
				if (ph_q == 2'd0) begin
					if (q_cmd.sda) begin
						priority if (st_q == S_WORD_ACK) begin
							r.status = STAT_WA_NACK;
						end else if (st_q == S_DATA_ACK) begin
							r.status = STAT_DAT_NACK;
						end else begin
							r.status = STAT_DEV_NACK;
						end
						lst_d      = r.status;
						r.done_res = 1'b1;
						st_d       = S_IDLE;
					end else begin
						ph_d = 2'd1;
					end
				end else begin
					r.scl = 1'b0;
					ph_d  = 2'd0;
					bit_d = 3'd0;
					priority if (st_q == S_DEVW_ACK) begin
						sh_d = addr_q;
						st_d = S_WORD;
					end else if (st_q == S_WORD_ACK) begin
						if (rd_q) begin
							st_d = S_RSTART;
						end else begin
							st_d = (left_q != 9'd0) ? S_WAIT : S_STOP;
						end
					end else if (st_q == S_DATA_ACK) begin
						left_d = left_dec;
						st_d   = (left_dec != 9'd0) ? S_WAIT : S_STOP;
					end else begin
						sh_d = 8'd0;
						st_d = S_RECV;
					end
				end
			end
			S_WAIT: begin
				r.scl = 1'b0;
				if (q_cmd.supply_op) begin
					sh_d  = q_cmd.tx_byte;
					ph_d  = 2'd0;
					bit_d = 3'd0;
					st_d  = S_DATA;
				end
			end
			S_RECV: begin
				if (ph_q == 2'd0) begin
					sh_d = {sh_q[6:0], q_cmd.sda};
					ph_d = 2'd1;
				end else begin
					r.scl = 1'b0;
					ph_d  = 2'd0;
					if (bit_q != 3'd7) begin
						bit_d = bit_q + 3'd1;
					end else begin
						bit_d     = 3'd0;
						r.rx_valid = 1'b1;
						r.rx_byte  = sh_q;
						st_d      = S_MACK;
					end
				end
			end
			S_MACK: begin
				// ACK every byte but the last
				r.sda_release = !(left_q > 9'd1);
				r.scl         = (ph_q == 2'd1);
				if (ph_q != 2'd2) begin
					ph_d = ph_q + 2'd1;
				end else begin
					ph_d   = 2'd0;
					left_d = left_dec;
					sh_d   = 8'd0;
					bit_d  = 3'd0;
					st_d   = (left_dec != 9'd0) ? S_RECV : S_STOP;
				end
			end
			S_STOP: begin
				if (ph_q == 2'd0) begin
					r.scl         = 1'b0;
					r.sda_release = 1'b0;
					ph_d = 2'd1;
				end else if (ph_q == 2'd1) begin
					r.sda_release = 1'b0;
					ph_d = 2'd2;
				end else begin
					ph_d       = 2'd0;
					r.done_res = 1'b1;
					r.status   = lst_q;
					st_d       = S_IDLE;
				end
			end
			default: begin
				st_d  = S_IDLE;
				ph_d  = 2'd0;
				bit_d = 3'd0;
			end
		endcase

		r.busy_res  = (st_d != S_IDLE);
		r.need_data = (st_d == S_WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ph_q        <= 2'd0;
			bit_q       <= 3'd0;
			sh_q        <= 8'd0;
			left_q      <= 9'd0;
			addr_q      <= 8'd0;
			rd_q        <= 1'b0;
			lst_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q   <= st_d;
				ph_q   <= ph_d;
				bit_q  <= bit_d;
				sh_q   <= sh_d;
				left_q <= left_d;
				addr_q <= addr_d;
				rd_q   <= rd_d;
				lst_q  <= lst_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= r;
		end
	end

endmodule

// ===== src/i2c_eeprom_transaction_master.sv =====
// Serial-EEPROM transaction master, one bus phase per input beat.
// A beat passes through the front register, the two-entry queue and the engine
// output register before its result beat shows.
// Throughput: one beat per cycle while the result channel does not stall; the engine updates one phase per popped beat.
// Reset (arst_n low, asynchronous): engine idle, queue empty, device
// address back to 80.
module i2c_eeprom_transaction_master import i2cee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  word_addr,
	input  logic [8:0]  byte_count,
	input  logic [7:0]  tx_byte,
	input  logic        sda_in,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl,
	output logic        sda_release,
	output logic        busy_res,
	output logic        need_data,
	output logic        rx_valid,
	output logic [7:0]  rx_byte,
	output logic        done_res,
	output logic [1:0]  status,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0] dev_addr_q;
	logic       push;
	cmd_t       push_cmd;
	logic       q_ready;
	logic       q_valid;
	cmd_t       q_cmd;
	logic       pop;
	res_t       res;

	// Register port: one register (device address) at byte offset 0.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DEV) ? {25'd0, dev_addr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_DEV)) begin
			dev_addr_q <= pwdata[6:0];
		end
	end

	// Front: takes beats, saturates counts, decodes opcode.
	i2cee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.word_addr  (word_addr),
		.byte_count (byte_count),
		.tx_byte    (tx_byte),
		.sda_in     (sda_in),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_ready    (q_ready)
	);

	// Two-entry queue lets front and engine stall independently.
	i2cee_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_ready  (q_ready),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop)
	);

	// Engine: bus sequencer, one phase per popped command, registered result.
	i2cee_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.dev_addr  (dev_addr_q),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	assign scl         = res.scl;
	assign sda_release = res.sda_release;
	assign busy_res    = res.busy_res;
	assign need_data   = res.need_data;
	assign rx_valid    = res.rx_valid;
	assign rx_byte     = res.rx_byte;
	assign done_res    = res.done_res;
	assign status      = res.status;

	// waiting for a write byte only happens mid-transaction
	a_need_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!need_data || busy_res))
		else $error("need_data without busy");

	// a finished transaction never coincides with a received byte
	a_rx_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rx_valid && done_res))
		else $error("rx_valid and done_res together");

	// a nonzero status is only reported on completion, and then engine is idle
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_OK)) |-> (done_res && !busy_res))
		else $error("error status outside completion");

endmodule

// ===== test/i2c_eeprom_transaction_master_test.sv =====
`timescale 1ns / 1ps

import i2cee_pkg::*;

// Sequencer steps of the transaction engine, in bus order.
typedef enum logic [4:0] {
	SQ_IDLE, SQ_START, SQ_DEVW, SQ_DEVW_ACK, SQ_WORD, SQ_WORD_ACK, SQ_WAIT,
	SQ_DATA, SQ_DATA_ACK, SQ_RSTART, SQ_DEVR, SQ_DEVR_ACK, SQ_RECV, SQ_MACK, SQ_STOP
} seq_t;

typedef struct packed {
	logic [1:0] op;
	logic [7:0] word_addr;
	logic [8:0] count;
	logic [7:0] tx_byte;
	logic       sda;
} bus_beat_t;

function automatic bit awaiting_ack(seq_t s);
	return s inside {SQ_DEVW_ACK, SQ_WORD_ACK, SQ_DATA_ACK, SQ_DEVR_ACK};
endfunction

// Tracks the bus engine one phase per accepted beat and checks result beats.
class eeprom_bus_scoreboard;
	seq_t       seq;
	logic [1:0] phase;
	logic [3:0] bit_pos;
	logic [7:0] shifter;
	logic [8:0] bytes_left;
	logic [7:0] mem_addr;
	logic       reading;
	logic [1:0] last_code;
	logic [6:0] dev_addr;
	res_t       expected_phases[$];
	int         errors;
	int         phases_seen;
	int         closed;
	int         nacked;
	int         bytes_read;

	function new();
		seq        = SQ_IDLE;
		phase      = '0;
		bit_pos    = '0;
		shifter    = '0;
		bytes_left = '0;
		mem_addr   = '0;
		reading    = 1'b0;
		last_code  = STAT_OK;
		dev_addr   = DEV_ADDR_RESET;
	endfunction

	function void note_beat(bus_beat_t b);
		res_t       r;
		logic [8:0] cnt;
		logic [1:0] code;
		r = '0;
		r.scl = 1'b1;
		r.sda_release = 1'b1;
		cnt = b.count;
		case (seq)
			SQ_IDLE: begin
				if (b.op == OP_WRITE || b.op == OP_READ) begin
					reading  = (b.op == OP_READ);
					mem_addr = b.word_addr;
					if (cnt > MAX_BYTE_COUNT)
						cnt = MAX_BYTE_COUNT;
					if (reading && cnt == 0)
						cnt = 9'd1;
					bytes_left = cnt;
					last_code  = STAT_OK;
					phase      = 0;
					bit_pos    = 0;
					seq        = SQ_START;
				end
			end
			SQ_START, SQ_RSTART: begin
				if (phase == 0) begin
					phase = 1;
				end else if (phase == 1) begin
					r.sda_release = 1'b0;
					phase = 2;
				end else begin
					r.scl = 1'b0;
					r.sda_release = 1'b0;
					shifter = {dev_addr, seq == SQ_RSTART};
					seq     = (seq == SQ_START) ? SQ_DEVW : SQ_DEVR;
					phase   = 0;
					bit_pos = 0;
				end
			end
			SQ_DEVW, SQ_WORD, SQ_DATA, SQ_DEVR: begin
				r.sda_release = shifter[3'd7 - bit_pos[2:0]];
				r.scl = (phase == 1);
				if (phase < 2) begin
					phase++;
				end else begin
					phase = 0;
					if (bit_pos < 7) begin
						bit_pos++;
					end else begin
						bit_pos = 0;
						seq = seq.next();
					end
				end
			end
			SQ_DEVW_ACK, SQ_WORD_ACK, SQ_DATA_ACK, SQ_DEVR_ACK: begin
				if (phase == 0) begin
					if (b.sda) begin
						code = (seq == SQ_WORD_ACK) ? STAT_WA_NACK :
							(seq == SQ_DATA_ACK) ? STAT_DAT_NACK : STAT_DEV_NACK;
						last_code  = code;
						r.done_res = 1'b1;
						r.status   = code;
						seq        = SQ_IDLE;
					end else begin
						phase = 1;
					end
				end else begin
					r.scl   = 1'b0;
					phase   = 0;
					bit_pos = 0;
					case (seq)
						SQ_DEVW_ACK: begin
							shifter = mem_addr;
							seq     = SQ_WORD;
						end
						SQ_WORD_ACK: begin
							if (reading)
								seq = SQ_RSTART;
							else
								seq = (bytes_left != 0) ? SQ_WAIT : SQ_STOP;
						end
						SQ_DATA_ACK: begin
							if (bytes_left > 0)
								bytes_left--;
							seq = (bytes_left != 0) ? SQ_WAIT : SQ_STOP;
						end
						default: begin
							shifter = '0;
							seq     = SQ_RECV;
						end
					endcase
				end
			end
			SQ_WAIT: begin
				r.scl = 1'b0;
				if (b.op == OP_SUPPLY) begin
					shifter = b.tx_byte;
					phase   = 0;
					bit_pos = 0;
					seq     = SQ_DATA;
				end
			end
			SQ_RECV: begin
				if (phase == 0) begin
					shifter = {shifter[6:0], b.sda};
					phase   = 1;
				end else begin
					r.scl = 1'b0;
					phase = 0;
					if (bit_pos < 7) begin
						bit_pos++;
					end else begin
						bit_pos    = 0;
						r.rx_valid = 1'b1;
						r.rx_byte  = shifter;
						seq        = SQ_MACK;
					end
				end
			end
			SQ_MACK: begin
				// ACK every byte but the last, NACK the last
				r.sda_release = (bytes_left > 9'd1) ? 1'b0 : 1'b1;
				r.scl = (phase == 1);
				if (phase < 2) begin
					phase++;
				end else begin
					phase = 0;
					if (bytes_left > 0)
						bytes_left--;
					shifter = '0;
					bit_pos = 0;
					seq     = (bytes_left != 0) ? SQ_RECV : SQ_STOP;
				end
			end
			SQ_STOP: begin
				if (phase == 0) begin
					r.scl = 1'b0;
					r.sda_release = 1'b0;
					phase = 1;
				end else if (phase == 1) begin
					r.sda_release = 1'b0;
					phase = 2;
				end else begin
					phase      = 0;
					r.done_res = 1'b1;
					r.status   = last_code;
					seq        = SQ_IDLE;
				end
			end
			default: begin
				seq     = SQ_IDLE;
				phase   = 0;
				bit_pos = 0;
			end
		endcase
		r.busy_res  = (seq != SQ_IDLE);
		r.need_data = (seq == SQ_WAIT);
		expected_phases.push_back(r);
	endfunction

	function void match_field(string label, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
		end
	endfunction

	function void check_phase(res_t got);
		res_t want;
		if (expected_phases.size() == 0) begin
			errors++;
			$display("%0t: result beat with nothing expected, got %h", $time, got);
			return;
		end
		want = expected_phases.pop_front();
		phases_seen++;
		if (want.done_res) begin
			closed++;
			if (want.status != STAT_OK)
				nacked++;
		end
		if (want.rx_valid)
			bytes_read++;
		match_field("scl", 8'(want.scl), 8'(got.scl));
		match_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
		match_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
		match_field("need_data", 8'(want.need_data), 8'(got.need_data));
		match_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
		match_field("rx_byte", want.rx_byte, got.rx_byte);
		match_field("done_res", 8'(want.done_res), 8'(got.done_res));
		match_field("status", 8'(want.status), 8'(got.status));
	endfunction
endclass

module i2c_eeprom_transaction_master_test;

	// Extra idle edges after the last expected beat returns cover the pipeline drain.
	localparam int SETTLE_CYCLES = 8;
	// Worst case ~2k beats, each slowed by sender gap, receiver stall and pipeline;
	// the limit takes that several times over.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_BEATS   = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [7:0]  word_addr;
	logic [8:0]  byte_count;
	logic [7:0]  tx_byte;
	logic        sda_in;
	logic        out_valid;
	logic        out_stall;
	logic        scl;
	logic        sda_release;
	logic        busy_res;
	logic        need_data;
	logic        rx_valid;
	logic [7:0]  rx_byte;
	logic        done_res;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	eeprom_bus_scoreboard sb = new();

	int cycle_count = 0;
	int settings    = 1;   // reset value counts as the first
	bit calm        = 1'b0; // both sides run without gaps while set

	i2c_eeprom_transaction_master dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Hard stop if the run hangs (lost result, stuck stall).
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d beats outstanding", $time, sb.expected_phases.size());
		$display("TB_ERROR");
		$finish;
	end

	// Result side: random stall per beat, every accepted beat goes to the scoreboard.
	initial begin : drain
		int   hold;
		res_t got;
		out_stall <= 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 14);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.scl         = scl;
			got.sda_release = sda_release;
			got.busy_res    = busy_res;
			got.need_data   = need_data;
			got.rx_valid    = rx_valid;
			got.rx_byte     = rx_byte;
			got.done_res    = done_res;
			got.status      = status;
			sb.check_phase(got);
		end
	end

	// One input beat: optional gap with valid low, then hold until taken.
	task automatic send_beat(input bus_beat_t b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode     <= b.op;
		word_addr  <= b.word_addr;
		byte_count <= b.count;
		tx_byte    <= b.tx_byte;
		sda_in     <= b.sda;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_beat(b);
	endtask

	// Setup then access; the idle edge at the end keeps back-to-back calls clean.
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_DEV;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register();
		logic [31:0] got;
		apb_access(1'b0, 32'd0, got);
		if (got !== {25'd0, sb.dev_addr}) begin
			sb.errors++;
			$display("%0t: device_address readback, expected %h, got %h",
				$time, {25'd0, sb.dev_addr}, got);
		end
	endtask

	task automatic set_device(input logic [6:0] value);
		logic [31:0] unused;
		apb_access(1'b1, {25'd0, value}, unused);
		sb.dev_addr = value;
		settings++;
		check_register();
	endtask

	// Block goes quiet: every expected beat back plus the pipeline drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_phases.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drives one whole transaction to completion. The slave refuses the ACK at
	// refuse_at (SQ_IDLE: never). Read data and write data alternate between
	// fill and ~fill per byte. Busy ticks mix in begin and stray-supply opcodes,
	// and each wait for data sees one plain tick before the byte arrives.
	task automatic run_transaction(input logic [1:0] code, input logic [7:0] addr,
			input logic [8:0] count, input seq_t refuse_at, input logic [7:0] fill);
		bus_beat_t  b;
		logic [7:0] pattern;
		int         k;
		bit         held;
		k    = 0;
		held = 1'b0;
		b.op        = code;
		b.word_addr = addr;
		b.count     = count;
		b.tx_byte   = fill;
		b.sda       = 1'b1;
		send_beat(b);
		while (sb.seq != SQ_IDLE) begin
			pattern     = sb.bytes_left[0] ? fill : ~fill;
			b.word_addr = ~addr;
			b.count     = ~count;
			b.tx_byte   = ~pattern;
			b.sda       = 1'($urandom_range(0, 1));
			case (k % 8)
				5: b.op = OP_WRITE;
				6: b.op = OP_READ;
				7: b.op = OP_SUPPLY;
				default: b.op = OP_TICK;
			endcase
			k++;
			if (sb.seq == SQ_WAIT) begin
				b.op      = held ? OP_SUPPLY : OP_TICK;
				b.tx_byte = pattern;
				held      = !held;
			end else if (awaiting_ack(sb.seq) && sb.phase == 0) begin
				b.sda = (sb.seq == refuse_at);
			end else if (sb.seq == SQ_RECV) begin
				b.sda = pattern[3'd7 - sb.bit_pos[2:0]];
			end
			send_beat(b);
		end
	endtask

	// Mostly short transfers, now and then long ones and oversized counts.
	function automatic logic [8:0] pick_count();
		int r;
		r = $urandom_range(0, 299);
		if (r == 0)
			return 9'($urandom_range(257, 511));
		if (r < 3)
			return 9'($urandom_range(200, 256));
		if (r < 30)
			return 9'($urandom_range(5, 16));
		return 9'($urandom_range(0, 4));
	endfunction

	// Random beat shaped by where the engine is: begins when idle, data when it
	// waits, slave ACKs nearly always given, noise opcodes on busy ticks.
	function automatic bus_beat_t next_random_beat();
		bus_beat_t b;
		b.word_addr = 8'($urandom_range(0, 255));
		b.count     = pick_count();
		b.tx_byte   = 8'($urandom_range(0, 255));
		b.sda       = 1'($urandom_range(0, 1));
		b.op        = ($urandom_range(0, 9) < 7) ? OP_TICK : 2'($urandom_range(0, 3));
		if (sb.seq == SQ_IDLE) begin
			if ($urandom_range(0, 9) != 0)
				b.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
		end else if (sb.seq == SQ_WAIT) begin
			if ($urandom_range(0, 7) != 0)
				b.op = OP_SUPPLY;
		end else if (awaiting_ack(sb.seq) && sb.phase == 0) begin
			b.sda = ($urandom_range(0, 29) == 0);
		end
		return b;
	endfunction

	task automatic random_phase(input int beats);
		bus_beat_t b;
		int        taken;
		taken = 0;
		while (taken < beats) begin
			b = next_random_beat();
			// beats the engine just ignores don't count
			if (!((sb.seq == SQ_IDLE && b.op != OP_WRITE && b.op != OP_READ) ||
					(sb.seq == SQ_WAIT && b.op != OP_SUPPLY)))
				taken++;
			if ($urandom_range(0, 99) == 0)
				calm = !calm;
			send_beat(b);
		end
	endtask

	initial begin : stimulus
		logic [6:0] dev_plan [5];
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		opcode     <= OP_TICK;
		word_addr  <= '0;
		byte_count <= '0;
		tx_byte    <= '0;
		sda_in     <= 1'b1;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= ADDR_DEV;
		pwdata     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_register();

		// directed: count extremes, data extremes, every NACK point
		run_transaction(OP_WRITE, 8'hFF, 9'd0, SQ_IDLE, 8'h00);       // zero-length write
		run_transaction(OP_READ, 8'h00, 9'd0, SQ_IDLE, 8'hA5);        // zero read becomes one
		run_transaction(OP_WRITE, 8'h5A, 9'd2, SQ_IDLE, 8'hFF);
		run_transaction(OP_READ, 8'hA5, 9'd3, SQ_IDLE, 8'hFF);
		run_transaction(OP_WRITE, 8'h01, 9'd1, SQ_DEVW_ACK, 8'h00);
		run_transaction(OP_WRITE, 8'h80, 9'd1, SQ_WORD_ACK, 8'h00);
		run_transaction(OP_WRITE, 8'h7F, 9'd3, SQ_DATA_ACK, 8'hC3);
		run_transaction(OP_READ, 8'hFE, 9'd1, SQ_DEVR_ACK, 8'h00);
		run_transaction(OP_WRITE, 8'h00, 9'd511, SQ_WORD_ACK, 8'h3C); // oversized, cut short

		// random phases across address settings, both extremes included
		dev_plan[0] = 7'd127;
		dev_plan[1] = 7'd0;
		dev_plan[2] = 7'($urandom_range(0, 127));
		dev_plan[3] = 7'($urandom_range(0, 127));
		dev_plan[4] = DEV_ADDR_RESET;
		random_phase(PHASE_BEATS);
		foreach (dev_plan[i]) begin
			settle();
			set_device(dev_plan[i]);
			random_phase(PHASE_BEATS);
		end

		settle();
		$display("Covered %0d bus phases over %0d device address settings.",
			sb.phases_seen, settings);
		$display("%0d transactions closed, %0d on a refused ACK; %0d bytes read.",
			sb.closed, sb.nacked, sb.bytes_read);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
